// ===== hw/rtl/cdpf_pkg.sv =====
// Shared types, constants and register codes for the CRC-32 data packet framer.
// No dependencies; every other framer file imports this package.
`timescale 1ns / 1ps

package cdpf_pkg;

  // Framing and CRC constants.
  localparam int          MAX_PAYLOAD_DEF = 1024;
  localparam logic [31:0] CRC_INIT        = 32'hFFFF_FFFF;
  localparam logic [31:0] CRC_POLY        = 32'h04C1_1DB7;
  localparam int          LEN_W           = 11;
  localparam int          ADDR_W          = 4;

  // Register reset values.
  localparam logic [7:0] START_MARKER_RST = 8'd170;
  localparam logic [7:0] END_MARKER_RST   = 8'd187;
  localparam logic [7:0] DATA_TYPE_RST    = 8'd1;

  // Register indexes (byte address divided by four).
  typedef enum logic [1:0] {
    REG_START_MARKER = 2'd0,
    REG_END_MARKER   = 2'd1,
    REG_DATA_TYPE    = 2'd2
  } reg_idx_t;

  // Position of a beat within the beats caused by one payload byte.
  typedef enum logic [3:0] {
    PH_START  = 4'd0,
    PH_TYPE   = 4'd1,
    PH_LEN_LO = 4'd2,
    PH_LEN_HI = 4'd3,
    PH_DATA   = 4'd4,
    PH_CRC0   = 4'd5,
    PH_CRC1   = 4'd6,
    PH_CRC2   = 4'd7,
    PH_CRC3   = 4'd8,
    PH_END    = 4'd9
  } phase_t;

  // Configuration values seen by the beat sequencer.
  typedef struct packed {
    logic [7:0] start_marker;
    logic [7:0] end_marker;
    logic [7:0] data_type;
  } cfg_t;

  // Everything needed to emit the beats of one payload byte.
  typedef struct packed {
    logic [7:0]       data;
    logic             first;
    logic             last;
    logic [LEN_W-1:0] len;
    logic [31:0]      crc;
  } desc_t;

endpackage

// ===== hw/rtl/crc32_data_packet_framer_unit.sv =====
// Top level of the CRC-32 data packet framer: register block, input stage and
// output sequencer. Depends on cdpf_pkg, cdpf_cfg_regs, cdpf_front, cdpf_seq.
`timescale 1ns / 1ps

// Each accepted payload byte gives one beat per cycle while out_ready is high:
// an inner byte its data beat only, the first byte of a packet the start
// marker, type and two length bytes before its data, the last byte four CRC
// bytes little-endian and the end marker after it, a one-byte packet all of
// these. The input stage holds one descriptor ahead of the sequencer, so the
// next byte is taken while the current byte's beats are still going out.
// The CRC is MSB-first, polynomial 0x04C11DB7, seeded with all ones, no final
// XOR, over the payload only. Registers: start marker at 0x0, end marker at
// 0x4, packet type at 0x8; write them only while the block is idle.
module crc32_data_packet_framer_unit import cdpf_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_data_byte,
  input  logic [LEN_W-1:0]  in_payload_length,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_byte,
  output logic              out_run_last,
  output logic              out_frame_last,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  cfg_t  cfg;
  desc_t desc;
  logic  desc_valid;
  logic  desc_take;

  // Configuration registers.
  cdpf_cfg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Packet state and CRC.
  cdpf_front #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data_byte      (in_data_byte),
    .in_payload_length (in_payload_length),
    .desc_valid        (desc_valid),
    .desc              (desc),
    .desc_take         (desc_take)
  );

  // Beat sequencer.
  cdpf_seq u_seq (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg),
    .desc_valid     (desc_valid),
    .desc           (desc),
    .desc_take      (desc_take),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_run_last   (out_run_last),
    .out_frame_last (out_frame_last)
  );

endmodule

// ===== hw/rtl/cdpf_cfg_regs.sv =====
// APB-style register block holding the marker and packet type bytes.
// Depends on cdpf_pkg.
`timescale 1ns / 1ps

module cdpf_cfg_regs import cdpf_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t     cfg_r;
  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[3:2]);
  assign cfg    = cfg_r;

  // Register writes; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_marker <= START_MARKER_RST;
      cfg_r.end_marker   <= END_MARKER_RST;
      cfg_r.data_type    <= DATA_TYPE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_START_MARKER: cfg_r.start_marker <= pwdata[7:0];
        REG_END_MARKER:   cfg_r.end_marker   <= pwdata[7:0];
        REG_DATA_TYPE:    cfg_r.data_type    <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read mux.
  always_comb begin
    unique case (idx)
      REG_START_MARKER: prdata = {24'd0, cfg_r.start_marker};
      REG_END_MARKER:   prdata = {24'd0, cfg_r.end_marker};
      REG_DATA_TYPE:    prdata = {24'd0, cfg_r.data_type};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// ===== hw/rtl/cdpf_front.sv =====
// Input stage: tracks packet state, updates the running CRC and registers one
// beat descriptor per payload byte. Depends on cdpf_pkg.
`timescale 1ns / 1ps

module cdpf_front import cdpf_pkg::*; #(
  parameter int MAX_PAYLOAD = MAX_PAYLOAD_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [7:0]       in_data_byte,
  input  logic [LEN_W-1:0] in_payload_length,
  output logic             desc_valid,
  output desc_t            desc,
  input  logic             desc_take
);

  localparam logic [15:0] MaxLen = 16'(MAX_PAYLOAD);

  logic             in_packet_r, in_packet_nxt;
  logic [LEN_W-1:0] bytes_left_r, bytes_left_nxt;
  logic [31:0]      crc_r, crc_nxt;
  logic             dvalid_r;
  desc_t            desc_r, desc_nxt;
  logic             acc;
  logic [LEN_W-1:0] len_sat;
  logic [LEN_W-1:0] count;
  logic [31:0]      crc_in;

  // One MSB-first CRC byte update, eight shift steps.
  function automatic logic [31:0] crc_byte(logic [31:0] crc, logic [7:0] b);
    logic [31:0] c;
    c = crc ^ {b, 24'd0};
    for (int i = 0; i < 8; i++) begin
      c = c[31] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  assign in_ready   = !dvalid_r || desc_take;
  assign acc        = in_valid && in_ready;
  assign desc_valid = dvalid_r;
  assign desc       = desc_r;

  // Length clamp: zero counts as one, oversize saturates.
  always_comb begin
    if (in_payload_length == '0) begin
      len_sat = LEN_W'(1);
    end else if (16'(in_payload_length) > MaxLen) begin
      len_sat = MaxLen[LEN_W-1:0];
    end else begin
      len_sat = in_payload_length;
    end
  end

  // Next packet state and descriptor for the byte on the input.
  always_comb begin
    count              = in_packet_r ? bytes_left_r : len_sat;
    crc_in             = in_packet_r ? crc_r : CRC_INIT;
    desc_nxt.data      = in_data_byte;
    desc_nxt.first     = !in_packet_r;
    desc_nxt.len       = len_sat;
    desc_nxt.crc       = crc_byte(crc_in, in_data_byte);
    bytes_left_nxt     = count - LEN_W'(1);
    desc_nxt.last      = (bytes_left_nxt == '0);
    in_packet_nxt      = !desc_nxt.last;
    crc_nxt            = desc_nxt.last ? CRC_INIT : desc_nxt.crc;
  end

  // Packet state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_packet_r  <= 1'b0;
      bytes_left_r <= '0;
      crc_r        <= CRC_INIT;
    end else if (acc) begin
      in_packet_r  <= in_packet_nxt;
      bytes_left_r <= bytes_left_nxt;
      crc_r        <= crc_nxt;
    end
  end

  // Descriptor slot.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dvalid_r <= 1'b0;
    end else if (acc) begin
      dvalid_r <= 1'b1;
    end else if (desc_take) begin
      dvalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      desc_r <= desc_nxt;
    end
  end

  // Idle state carries no leftover count or CRC.
  a_idle_count: assert property (@(posedge clk) disable iff (!rst_n)
    !in_packet_r |-> bytes_left_r == '0) else $error("count left while idle");
  a_idle_crc: assert property (@(posedge clk) disable iff (!rst_n)
    !in_packet_r |-> crc_r == CRC_INIT) else $error("CRC not reset while idle");
  a_close: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && desc_nxt.last) |=> !in_packet_r) else $error("packet not closed");

endmodule

// ===== hw/rtl/cdpf_seq.sv =====
// Output sequencer: walks the header, payload, CRC and end marker beats of one
// descriptor, one beat per cycle while out_ready is high. Depends on cdpf_pkg.
`timescale 1ns / 1ps

module cdpf_seq import cdpf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       desc_valid,
  input  desc_t      desc,
  output logic       desc_take,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_frame_last
);

  logic   svalid_r;
  desc_t  s_r;
  phase_t ph_r, ph_nxt;
  phase_t ph_final;
  logic   beat;
  logic   done;

  assign ph_final       = s_r.last ? PH_END : PH_DATA;
  assign beat           = svalid_r && out_ready;
  assign done           = beat && (ph_r == ph_final);
  assign desc_take      = desc_valid && (!svalid_r || done);
  assign out_valid      = svalid_r;
  assign out_run_last   = (ph_r == ph_final);
  assign out_frame_last = (ph_r == PH_END);

  // Beat position.
  always_comb begin
    if (desc_take) begin
      ph_nxt = desc.first ? PH_START : PH_DATA;
    end else if (beat && !done) begin
      ph_nxt = phase_t'(ph_r + 4'd1);
    end else begin
      ph_nxt = ph_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      svalid_r <= 1'b0;
      ph_r     <= PH_DATA;
    end else begin
      ph_r <= ph_nxt;
      if (desc_take) begin
        svalid_r <= 1'b1;
      end else if (done) begin
        svalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (desc_take) begin
      s_r <= desc;
    end
  end

  // Byte select for the current beat.
  always_comb begin
    unique case (ph_r)
      PH_START:  out_byte = cfg.start_marker;
      PH_TYPE:   out_byte = cfg.data_type;
      PH_LEN_LO: out_byte = s_r.len[7:0];
      PH_LEN_HI: out_byte = {{(16 - LEN_W){1'b0}}, s_r.len[LEN_W-1:8]};
      PH_DATA:   out_byte = s_r.data;
      PH_CRC0:   out_byte = s_r.crc[7:0];
      PH_CRC1:   out_byte = s_r.crc[15:8];
      PH_CRC2:   out_byte = s_r.crc[23:16];
      PH_CRC3:   out_byte = s_r.crc[31:24];
      PH_END:    out_byte = cfg.end_marker;
      default:   out_byte = s_r.data;
    endcase
  end

  a_no_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    (svalid_r && !s_r.first) |-> ph_r >= PH_DATA) else $error("header beat on later byte");
  a_no_trl: assert property (@(posedge clk) disable iff (!rst_n)
    (svalid_r && !s_r.last) |-> ph_r <= PH_DATA) else $error("trailer beat on inner byte");
  a_frame_run: assert property (@(posedge clk) disable iff (!rst_n)
    (svalid_r && out_frame_last) |-> out_run_last) else $error("end marker not run end");

endmodule
